// ===== hw/rtl/mec_pkg.sv =====
// Shared types and constants for the multi-car elevator controller.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package mec_pkg;

  localparam int FLOOR_COUNT = 16;
  localparam int CAR_COUNT   = 3;

  localparam int FLOOR_IW = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
  localparam int CAR_IW   = (CAR_COUNT > 1) ? $clog2(CAR_COUNT) : 1;

  // fixed field widths of the ports
  localparam int CMD_W   = 3;
  localparam int CAR_W   = 2;
  localparam int FLOOR_W = 4;
  localparam int ACT_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSIDE     = 3'd0,
    CMD_OUT_UP     = 3'd1,
    CMD_OUT_DOWN   = 3'd2,
    CMD_ARRIVE     = 3'd3,
    CMD_DOOR_OPEN  = 3'd4,
    CMD_DOOR_CLOSE = 3'd5,
    CMD_TICK       = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_UP      = 3'd1,
    MODE_DOWN    = 3'd2,
    MODE_STOPPED = 3'd3,
    MODE_OPENING = 3'd4,
    MODE_CLOSING = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_MAND = 2'd1,
    REQ_UP   = 2'd2,
    REQ_DOWN = 2'd3
  } req_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_LIGHT     = 3'd0,
    ACT_UP        = 3'd1,
    ACT_DOWN      = 3'd2,
    ACT_STOP      = 3'd3,
    ACT_LIGHT_OFF = 3'd4,
    ACT_OPEN      = 3'd5,
    ACT_CLOSE     = 3'd6
  } action_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic load;     // fetch the addressed car's state
    logic exec;     // apply the request and register its results
    logic sel;      // which registered result drives the output
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] exec_n;  // result count of the request being executed
    logic [1:0] held_n;  // result count held for output
  } dp_status_t;

endpackage

// ===== hw/rtl/mec_datapath.sv =====
// Datapath: per-car request rows and car state, request decode and the tick rule.
// Depends on mec_pkg; sequenced by mec_controller.
`timescale 1ns / 1ps

module mec_datapath import mec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [CAR_W-1:0]    car_i,
  input  logic [FLOOR_W-1:0]  floor_i,
  output logic [CAR_W-1:0]    target_car_o,
  output logic [ACT_W-1:0]    action_o,
  output logic [FLOOR_W-1:0]  action_floor_o,
  output logic                last_o
);

  // architectural state of all cars
  req_e                rows_q   [CAR_COUNT][FLOOR_COUNT];
  logic [FLOOR_IW-1:0] floor_q  [CAR_COUNT];
  mode_e               mode_q   [CAR_COUNT];
  dir_e                ldir_q   [CAR_COUNT];
  logic                opened_q [CAR_COUNT];
  logic                closed_q [CAR_COUNT];

  // captured request
  logic [CMD_W-1:0]   cmd_q;
  logic [CAR_W-1:0]   car_q;
  logic [FLOOR_W-1:0] fl_q;

  // working copy of the addressed car
  req_e                row_q [FLOOR_COUNT];
  logic [FLOOR_IW-1:0] here_q;
  mode_e               cmode_q;
  dir_e                cldir_q;
  logic                copened_q;
  logic                cclosed_q;

  // registered results
  logic [1:0]         n_q;
  action_e            act0_q;
  action_e            act1_q;
  logic [FLOOR_W-1:0] fl0_q;

  logic [CAR_IW-1:0]   car_ix;
  logic [FLOOR_IW-1:0] fl_ix;
  logic                item_ok;

  assign car_ix  = CAR_IW'(car_q);
  assign fl_ix   = FLOOR_IW'(fl_q);
  assign item_ok = (32'(car_q) < CAR_COUNT) &&
                   !((cmd_q <= CMD_ARRIVE) && (32'(fl_q) >= FLOOR_COUNT)) &&
                   (cmd_q <= CMD_TICK);

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      car_q <= car_i;
      fl_q  <= floor_i;
    end
  end

  // fetch of the addressed car
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q     <= rows_q[car_ix];
      here_q    <= floor_q[car_ix];
      cmode_q   <= mode_q[car_ix];
      cldir_q   <= ldir_q[car_ix];
      copened_q <= opened_q[car_ix];
      cclosed_q <= closed_q[car_ix];
    end
  end

  // row masks relative to the current floor
  logic [FLOOR_COUNT-1:0] pend, gt_m, lt_m, here_oh, pend_ex, low_bit;

  always_comb begin
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      pend[i]    = (row_q[i] != REQ_NONE);
      gt_m[i]    = (i > int'(here_q));
      lt_m[i]    = (i < int'(here_q));
      here_oh[i] = (i == int'(here_q));
    end
  end

  assign pend_ex = pend & ~here_oh;
  assign low_bit = pend_ex & (~pend_ex + FLOOR_COUNT'(1));

  // request decode and mode rule
  logic [1:0]          n_d;
  action_e             act0_d, act1_d;
  logic [FLOOR_W-1:0]  fl0_d;
  mode_e               mode_d;
  dir_e                ldir_d;
  logic                opened_d, closed_d, floor_we, row_we;
  logic [FLOOR_IW-1:0] row_wa;
  req_e                row_wd;
  logic                up, halt;
  req_e                r_here;

  assign r_here = row_q[here_q];

  always_comb begin
    n_d      = 2'd0;
    act0_d   = ACT_LIGHT;
    act1_d   = ACT_LIGHT;
    fl0_d    = '0;
    mode_d   = cmode_q;
    ldir_d   = cldir_q;
    opened_d = copened_q;
    closed_d = cclosed_q;
    floor_we = 1'b0;
    row_we   = 1'b0;
    row_wa   = fl_ix;
    row_wd   = REQ_NONE;
    up       = (cmode_q == MODE_UP);
    halt     = 1'b0;
    if (item_ok) begin
      case (cmd_q)
        CMD_INSIDE: begin
          row_we = 1'b1;
          row_wd = REQ_MAND;
          n_d    = 2'd1;
          act0_d = ACT_LIGHT;
          fl0_d  = fl_q;
        end
        CMD_OUT_UP: begin
          row_we = 1'b1;
          row_wd = REQ_UP;
        end
        CMD_OUT_DOWN: begin
          row_we = 1'b1;
          row_wd = REQ_DOWN;
        end
        CMD_ARRIVE:     floor_we = 1'b1;
        CMD_DOOR_OPEN:  opened_d = 1'b1;
        CMD_DOOR_CLOSE: closed_d = 1'b1;
        CMD_TICK: begin
          case (cmode_q)
            MODE_IDLE: begin
              ldir_d = DIR_NONE;
              if (|pend_ex) begin
                n_d = 2'd1;
                if (|(low_bit & gt_m)) begin
                  act0_d = ACT_UP;
                  mode_d = MODE_UP;
                end else begin
                  act0_d = ACT_DOWN;
                  mode_d = MODE_DOWN;
                end
              end
            end
            MODE_UP, MODE_DOWN: begin
              ldir_d = up ? DIR_UP : DIR_DOWN;
              if (r_here == REQ_MAND || r_here == (up ? REQ_UP : REQ_DOWN)) begin
                halt = 1'b1;
              end else if (r_here == (up ? REQ_DOWN : REQ_UP)) begin
                halt = up ? !(|(pend & gt_m)) : !(|(pend & lt_m));
              end
              if (halt) begin
                n_d    = 2'd1;
                act0_d = ACT_STOP;
                row_we = 1'b1;
                row_wa = here_q;
                row_wd = REQ_NONE;
                mode_d = MODE_STOPPED;
              end
            end
            MODE_STOPPED: begin
              n_d    = 2'd2;
              act0_d = ACT_LIGHT_OFF;
              fl0_d  = FLOOR_W'(here_q);
              act1_d = ACT_OPEN;
              mode_d = MODE_OPENING;
            end
            MODE_OPENING: begin
              if (copened_q) begin
                opened_d = 1'b0;
                n_d      = 2'd1;
                act0_d   = ACT_CLOSE;
                mode_d   = MODE_CLOSING;
              end
            end
            MODE_CLOSING: begin
              if (cclosed_q) begin
                closed_d = 1'b0;
                mode_d   = MODE_IDLE;
                if (cldir_q == DIR_UP && |(pend & ~lt_m)) begin
                  n_d    = 2'd1;
                  act0_d = ACT_UP;
                  mode_d = MODE_UP;
                end else if (cldir_q == DIR_DOWN && |(pend & ~gt_m)) begin
                  n_d    = 2'd1;
                  act0_d = ACT_DOWN;
                  mode_d = MODE_DOWN;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CAR_COUNT; c++) begin
        for (int f = 0; f < FLOOR_COUNT; f++) begin
          rows_q[c][f] <= REQ_NONE;
        end
        floor_q[c]  <= '0;
        mode_q[c]   <= MODE_IDLE;
        ldir_q[c]   <= DIR_NONE;
        opened_q[c] <= 1'b0;
        closed_q[c] <= 1'b0;
      end
    end else if (cmd_i.exec && item_ok) begin
      if (row_we) begin
        rows_q[car_ix][row_wa] <= row_wd;
      end
      if (floor_we) begin
        floor_q[car_ix] <= fl_ix;
      end
      mode_q[car_ix]   <= mode_d;
      ldir_q[car_ix]   <= ldir_d;
      opened_q[car_ix] <= opened_d;
      closed_q[car_ix] <= closed_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      n_q    <= n_d;
      act0_q <= act0_d;
      act1_q <= act1_d;
      fl0_q  <= fl0_d;
    end
  end

  assign status_o.exec_n = n_d;
  assign status_o.held_n = n_q;

  // output select
  assign target_car_o   = car_q;
  assign action_o       = cmd_i.sel ? act1_q : act0_q;
  assign action_floor_o = cmd_i.sel ? '0 : fl0_q;
  assign last_o         = cmd_i.sel || (n_q == 2'd1);

endmodule

// ===== hw/rtl/mec_controller.sv =====
// Controller: sequences capture, fetch, execute and result delivery.
// Depends on mec_pkg; drives mec_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module mec_controller import mec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_OUT0 = 5'b01000,
    ST_OUT1 = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   in_acc, out_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT0) || (state_q == ST_OUT1);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_EXEC;
      ST_EXEC: state_d = (status_i.exec_n == 2'd0) ? ST_IDLE : ST_OUT0;
      ST_OUT0: begin
        if (out_acc) state_d = (status_i.held_n == 2'd2) ? ST_OUT1 : ST_IDLE;
      end
      ST_OUT1: if (out_acc) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath commands
  assign cmd_o.capture = in_acc;
  assign cmd_o.load    = (state_q == ST_LOAD);
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.sel     = (state_q == ST_OUT1);

  // no request is taken while a result is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request accepted while a result is pending");

  // a request never yields more than two results
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> (status_i.exec_n != 2'd3))
    else $error("result count out of range");

  // the second result is offered only for a two-result request
  a_second_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT1) |-> (status_i.held_n == 2'd2))
    else $error("second result without a two-result request");

  // an accepted request passes through the fetch state into execution
  a_exec_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##2 cmd_o.exec)
    else $error("accepted request was not executed");

endmodule

// ===== hw/rtl/multi_car_elevator_controller_core.sv =====
// Multi-car elevator controller: one request in, up to two commands out.
// A request is accepted only while idle; it then passes through car fetch and execute, after which
// its results are offered one at a time; a request without results returns straight to idle.
// No new request is taken until every result of the last one has been taken by the sink,
// so a stalled sink holds the input.
// Reset (async, active low): all request rows cleared, cars idle at floor 0, flags cleared.
`timescale 1ns / 1ps

module multi_car_elevator_controller_core import mec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [CAR_W-1:0]   car_i,
  input  logic [FLOOR_W-1:0] floor_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CAR_W-1:0]   target_car_o,
  output logic [ACT_W-1:0]   action_o,
  output logic [FLOOR_W-1:0] action_floor_o,
  output logic               last_o
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // sequencer
  mec_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (ctrl_cmd),
    .status_i    (dp_status)
  );

  // car state and decision logic
  mec_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status),
    .command_i      (command_i),
    .car_i          (car_i),
    .floor_i        (floor_i),
    .target_car_o   (target_car_o),
    .action_o       (action_o),
    .action_floor_o (action_floor_o),
    .last_o         (last_o)
  );

endmodule

// ===== tb/elevator_command_checker.sv =====
// Request/command checker for the multi-car elevator controller core.
// Mirrors the per-car request rows and mode machines and compares every command; uses mec_pkg.
`timescale 1ns / 1ps

module elevator_command_checker import mec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [CAR_W-1:0]   car_i,
  input  logic [FLOOR_W-1:0] floor_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [CAR_W-1:0]   target_car_i,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [FLOOR_W-1:0] action_floor_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_count_o
);

  typedef struct packed {
    logic [CAR_W-1:0]   car;
    action_e            act;
    logic [FLOOR_W-1:0] fl;
    logic               last;
  } car_command_t;

  // commands still owed by the controller, oldest first
  car_command_t expected_cmds[$];

  // mirror of the controller state
  req_e               request_rows[CAR_COUNT][FLOOR_COUNT];
  logic [FLOOR_W-1:0] car_floor[CAR_COUNT];
  mode_e              car_mode[CAR_COUNT];
  dir_e               travel_dir[CAR_COUNT];
  logic               door_opened[CAR_COUNT];
  logic               door_closed[CAR_COUNT];

  // work out the commands one request causes and queue them
  task automatic plan_commands(input logic [CMD_W-1:0] cmd, input logic [CAR_W-1:0] c,
                               input logic [FLOOR_W-1:0] fl);
    action_e            acts[2];
    logic [FLOOR_W-1:0] act_fl[2];
    int                 n;
    int                 i;
    int                 here;
    logic               going_up;
    logic               halt;
    logic               seen;
    req_e               code;
    car_command_t       item;
    n = 0;
    act_fl[0] = '0;
    act_fl[1] = '0;
    if (c >= CAR_COUNT) return;
    if (cmd <= CMD_ARRIVE && fl >= FLOOR_COUNT) return;
    case (cmd)
      CMD_INSIDE: begin
        request_rows[c][fl] = REQ_MAND;
        acts[0] = ACT_LIGHT;
        act_fl[0] = fl;
        n = 1;
      end
      CMD_OUT_UP:     request_rows[c][fl] = REQ_UP;
      CMD_OUT_DOWN:   request_rows[c][fl] = REQ_DOWN;
      CMD_ARRIVE:     car_floor[c] = fl;
      CMD_DOOR_OPEN:  door_opened[c] = 1'b1;
      CMD_DOOR_CLOSE: door_closed[c] = 1'b1;
      CMD_TICK: begin
        here = int'(car_floor[c]);
        case (car_mode[c])
          MODE_IDLE: begin
            // lowest pending floor other than the current one picks the direction
            travel_dir[c] = DIR_NONE;
            seen = 1'b0;
            for (i = 0; i < FLOOR_COUNT; i++) begin
              if (!seen && request_rows[c][i] != REQ_NONE && i != here) begin
                seen = 1'b1;
                acts[0] = (i > here) ? ACT_UP : ACT_DOWN;
                car_mode[c] = (i > here) ? MODE_UP : MODE_DOWN;
                n = 1;
              end
            end
          end
          MODE_UP, MODE_DOWN: begin
            going_up = (car_mode[c] == MODE_UP);
            travel_dir[c] = going_up ? DIR_UP : DIR_DOWN;
            code = request_rows[c][here];
            halt = 1'b0;
            if (code == REQ_MAND || code == (going_up ? REQ_UP : REQ_DOWN)) begin
              halt = 1'b1;
            end else if (code == (going_up ? REQ_DOWN : REQ_UP)) begin
              // opposite-direction call stops only at the end of the run
              seen = 1'b0;
              for (i = 0; i < FLOOR_COUNT; i++)
                if ((going_up ? (i > here) : (i < here)) && request_rows[c][i] != REQ_NONE)
                  seen = 1'b1;
              halt = !seen;
            end
            if (halt) begin
              acts[0] = ACT_STOP;
              request_rows[c][here] = REQ_NONE;
              car_mode[c] = MODE_STOPPED;
              n = 1;
            end
          end
          MODE_STOPPED: begin
            acts[0] = ACT_LIGHT_OFF;
            act_fl[0] = here[FLOOR_W-1:0];
            acts[1] = ACT_OPEN;
            car_mode[c] = MODE_OPENING;
            n = 2;
          end
          MODE_OPENING: begin
            if (door_opened[c]) begin
              door_opened[c] = 1'b0;
              acts[0] = ACT_CLOSE;
              car_mode[c] = MODE_CLOSING;
              n = 1;
            end
          end
          MODE_CLOSING: begin
            if (door_closed[c]) begin
              door_closed[c] = 1'b0;
              car_mode[c] = MODE_IDLE;
              // keep going the same way if anything lies at or beyond this floor
              if (travel_dir[c] == DIR_UP || travel_dir[c] == DIR_DOWN) begin
                going_up = (travel_dir[c] == DIR_UP);
                seen = 1'b0;
                for (i = 0; i < FLOOR_COUNT; i++)
                  if ((going_up ? (i >= here) : (i <= here)) &&
                      request_rows[c][i] != REQ_NONE)
                    seen = 1'b1;
                if (seen) begin
                  acts[0] = going_up ? ACT_UP : ACT_DOWN;
                  car_mode[c] = going_up ? MODE_UP : MODE_DOWN;
                  n = 1;
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    for (i = 0; i < n; i++) begin
      item.car  = c;
      item.act  = acts[i];
      item.fl   = act_fl[i];
      item.last = (i == n - 1);
      expected_cmds.push_back(item);
    end
  endtask

  // watch both channels: predict on each request, compare on each command
  always @(posedge clk_i or negedge rst_ni) begin : watch
    int           c;
    int           f;
    car_command_t want;
    if (!rst_ni) begin
      for (c = 0; c < CAR_COUNT; c++) begin
        for (f = 0; f < FLOOR_COUNT; f++) request_rows[c][f] = REQ_NONE;
        car_floor[c]   = '0;
        car_mode[c]    = MODE_IDLE;
        travel_dir[c]  = DIR_NONE;
        door_opened[c] = 1'b0;
        door_closed[c] = 1'b0;
      end
      expected_cmds.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) plan_commands(command_i, car_i, floor_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_cmds.size() == 0) begin
          $error("unexpected command: car %0d action %0d floor %0d last %0d",
                 target_car_i, action_i, action_floor_i, last_i);
          fail_count_o++;
        end else begin
          want = expected_cmds.pop_front();
          if (target_car_i !== want.car) begin
            $error("target_car: expected %0d, got %0d", want.car, target_car_i);
            fail_count_o++;
          end
          if (action_i !== want.act) begin
            $error("action: expected %0d, got %0d", want.act, action_i);
            fail_count_o++;
          end
          if (action_floor_i !== want.fl) begin
            $error("action_floor: expected %0d, got %0d", want.fl, action_floor_i);
            fail_count_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_count_o = expected_cmds.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for multi_car_elevator_controller_core: clock, reset, request stimulus, verdict.
// Depends on mec_pkg, the controller RTL and elevator_command_checker.
`timescale 1ns / 1ps

module tb import mec_pkg::*; ();

  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 500000;
  // command code with no meaning, must be dropped
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   command;
  logic [CAR_W-1:0]   car;
  logic [FLOOR_W-1:0] floor_num;
  logic               out_valid;
  logic               out_ready;
  logic [CAR_W-1:0]   target_car;
  logic [ACT_W-1:0]   action;
  logic [FLOOR_W-1:0] action_floor;
  logic               last;

  int                 fail_count;
  int                 pending_count;
  int                 cycle_count;
  int                 sent_items;
  int                 random_start;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  logic [FLOOR_W-1:0] car_at[CAR_COUNT];

  multi_car_elevator_controller_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .car_i          (car),
    .floor_i        (floor_num),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .target_car_o   (target_car),
    .action_o       (action),
    .action_floor_o (action_floor),
    .last_o         (last)
  );

  elevator_command_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .command_i       (command),
    .car_i           (car),
    .floor_i         (floor_num),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .target_car_i    (target_car),
    .action_i        (action),
    .action_floor_i  (action_floor),
    .last_i          (last),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // command sink stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // offer one request, optionally after idle cycles, and wait for it to be taken
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CAR_W-1:0] c,
                              input logic [FLOOR_W-1:0] fl);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    car       <= c;
    floor_num <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c < CAR_COUNT && cmd != CMD_UNUSED) begin
      sent_items++;
      if (cmd == CMD_ARRIVE) car_at[c] = fl;
    end
  endtask

  // stopped -> opening -> closing -> idle, sometimes with the door events swapped
  task automatic door_cycle(input logic [CAR_W-1:0] c);
    send_request(CMD_TICK, c, FLOOR_W'($urandom_range(15)));
    if ($urandom_range(4) == 0) begin
      send_request(CMD_DOOR_CLOSE, c, FLOOR_W'($urandom_range(15)));
      send_request(CMD_DOOR_OPEN, c, FLOOR_W'($urandom_range(15)));
      send_request(CMD_TICK, c, FLOOR_W'($urandom_range(15)));
    end else begin
      send_request(CMD_DOOR_OPEN, c, FLOOR_W'($urandom_range(15)));
      send_request(CMD_TICK, c, FLOOR_W'($urandom_range(15)));
      send_request(CMD_DOOR_CLOSE, c, FLOOR_W'($urandom_range(15)));
    end
    send_request(CMD_TICK, c, FLOOR_W'($urandom_range(15)));
  endtask

  // a plausible trip: calls, departure, floor-by-floor arrivals, door cycle at the goal
  task automatic run_trip(input logic [CAR_W-1:0] c);
    int                 stops;
    int                 k;
    logic [FLOOR_W-1:0] goal;
    logic [FLOOR_W-1:0] here;
    logic [CMD_W-1:0]   kind;
    stops = $urandom_range(1, 3);
    goal = '0;
    for (k = 0; k < stops; k++) begin
      goal = FLOOR_W'($urandom_range(15));
      case ($urandom_range(2))
        0:       kind = CMD_INSIDE;
        1:       kind = CMD_OUT_UP;
        default: kind = CMD_OUT_DOWN;
      endcase
      send_request(kind, c, goal);
    end
    send_request(CMD_TICK, c, FLOOR_W'($urandom_range(15)));
    here = car_at[c];
    while (here != goal) begin
      here = (goal > here) ? here + 1'b1 : here - 1'b1;
      send_request(CMD_ARRIVE, c, here);
      send_request(CMD_TICK, c, FLOOR_W'($urandom_range(15)));
      if ($urandom_range(9) == 0) door_cycle(c);
    end
    door_cycle(c);
  endtask

  initial begin
    int done;
    int k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    command     = CMD_INSIDE;
    car         = '0;
    floor_num   = '0;
    out_ready   = 1'b0;
    cycle_count = 0;
    sent_items  = 0;
    tx_idle_pct = 22;
    rx_idle_pct = 74;
    for (k = 0; k < CAR_COUNT; k++) car_at[k] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, dropped requests, both stop rules
    send_request(CMD_INSIDE, 2'd0, 4'd15);
    send_request(CMD_INSIDE, 2'd1, 4'd0);
    // pending call only at the idle floor: no move
    send_request(CMD_TICK, 2'd1, 4'd0);
    send_request(CMD_OUT_UP, 2'd2, 4'd5);
    send_request(CMD_OUT_DOWN, 2'd2, 4'd10);
    send_request(CMD_TICK, 2'd2, 4'd15);
    send_request(CMD_ARRIVE, 2'd2, 4'd5);
    send_request(CMD_TICK, 2'd2, 4'd0);
    send_request(CMD_TICK, 2'd2, 4'd0);
    // stray close while opening stays latched
    send_request(CMD_DOOR_CLOSE, 2'd2, 4'd15);
    send_request(CMD_TICK, 2'd2, 4'd0);
    send_request(CMD_DOOR_OPEN, 2'd2, 4'd0);
    send_request(CMD_TICK, 2'd2, 4'd0);
    // closed flag already set: resume upward
    send_request(CMD_TICK, 2'd2, 4'd0);
    // down-call with nothing above stops the upward run
    send_request(CMD_ARRIVE, 2'd2, 4'd10);
    send_request(CMD_TICK, 2'd2, 4'd0);
    // out-of-range car and unused command are dropped
    send_request(CMD_INSIDE, CAR_W'(CAR_COUNT), 4'd7);
    send_request(CMD_UNUSED, 2'd0, 4'd9);
    send_request(CMD_UNUSED, CAR_W'(CAR_COUNT), 4'd15);
    send_request(CMD_TICK, 2'd0, 4'd0);
    send_request(CMD_ARRIVE, 2'd0, 4'd15);
    send_request(CMD_TICK, 2'd0, 4'd0);
    // idle above the only call: move down
    send_request(CMD_ARRIVE, 2'd1, 4'd15);
    send_request(CMD_TICK, 2'd1, 4'd15);

    // random: mostly trips, some noise, three idling phases
    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      done = sent_items - random_start;
      if (done < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 22;
        rx_idle_pct = 74;
      end else if (done < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 74;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(9) < 8) begin
        run_trip(CAR_W'($urandom_range(CAR_COUNT - 1)));
      end else begin
        for (k = $urandom_range(1, 3); k > 0; k--)
          send_request(CMD_W'($urandom_range(7)), CAR_W'($urandom_range(3)),
                       FLOOR_W'($urandom_range(15)));
      end
    end
    in_valid <= 1'b0;

    // drain, then allow the last request's latency
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mec_pkg.sv
hw/rtl/mec_datapath.sv
hw/rtl/mec_controller.sv
hw/rtl/multi_car_elevator_controller_core.sv
tb/elevator_command_checker.sv
tb/tb.sv
